>>> src/text_tokenizer_stopword_filter_core_defines.svh
// Assertion macros used by the checker file of the stop-word filter.
// No dependencies.
`ifndef TEXT_TOKENIZER_STOPWORD_FILTER_CORE_DEFINES_SVH
`define TEXT_TOKENIZER_STOPWORD_FILTER_CORE_DEFINES_SVH
// Assert that cond implies a consequence in the same cycle.
`define TSF_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Assert that cond implies a consequence in the next cycle.
`define TSF_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

>>> src/tsf_pkg.sv
// Package of the stop-word filter: types, separator test, stop-word table.
// No dependencies.
package tsf_pkg;
    localparam int RowBytes = 16;
    typedef logic [RowBytes*8-1:0] t_row;

    function automatic logic is_sep(input logic [7:0] b);
        logic r;
        r = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
        case (b)
            ",", ".", "!", "?", ";", ":", "(", ")", "[", "]", "{", "}", 8'h22, "'",
            "-", "_", "/", 8'h5C, "|", "&", "*", "+", "=", "<", ">", "@", "#", "$",
            "%", "^": r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    // Pack a string into a row: first character in the lowest byte.
    function automatic t_row mk(input logic [RowBytes*8-1:0] s, input int n);
        t_row r;
        r = '0;
        for (int i = 0; i < RowBytes; i++)
            if (i < n) r[i*8 +: 8] = s[(n-1-i)*8 +: 8];
        return r;
    endfunction

    function automatic t_row rom_row(input int a);
        t_row r;
        case (a)
            0: r = mk(16'hd0b8, 2);   1: r = mk(16'hd0b2, 2);
            2: r = mk(32'hd0bdd0b0, 4); 3: r = mk(16'hd0be, 2);
            4: r = mk(16'hd181, 2);   5: r = mk(16'hd0ba, 2);
            6: r = mk(32'hd0bfd0be, 4); 7: r = mk(32'hd0b7d0b0, 4);
            8: r = mk(32'hd0bed182, 4); 9: r = mk(32'hd0b4d0be, 4);
            10: r = mk(48'hd0b4d0bbd18f, 6); 11: r = mk(16'hd0b0, 2);
            12: r = mk(32'hd0bdd0be, 4); 13: r = mk(64'hd0b8d0bbd0b8, 6);
            14: r = mk(32'hd0b6d0b5, 4); 15: r = mk(32'hd0bbd0b8, 4);
            16: r = mk(32'hd0b1d18b, 4); 17: r = mk(48'hd187d182d0be, 6);
            18: r = mk(48'hd0bad0b0d0ba, 6); 19: r = mk(48'hd0b3d0b4d0b5, 6);
            20: r = mk(80'hd0bad0bed0b3d0b4d0b0, 10);
            21: r = mk(48'hd0bad182d0be, 6); 22: r = mk(48'hd187d0b5d0bc, 6);
            23: r = mk(64'hd0bad0bed0bcd183, 8); 24: r = mk(48'hd0bad0b5d0bc, 6);
            25: r = mk(64'hd18dd182d0bed0bc, 8); 26: r = mk(64'hd18dd182d0bed182, 8);
            27: r = mk(64'hd18dd182d0b8, 6); 28: r = mk(48'hd18dd182d0b0, 6);
            29: r = mk(48'hd18dd182d0be, 6);
            30: r = mk("the", 3); 31: r = mk("a", 1); 32: r = mk("an", 2);
            33: r = mk("and", 3); 34: r = mk("or", 2); 35: r = mk("but", 3);
            36: r = mk("in", 2); 37: r = mk("on", 2); 38: r = mk("at", 2);
            39: r = mk("to", 2); 40: r = mk("for", 3); 41: r = mk("of", 2);
            42: r = mk("with", 4); 43: r = mk("by", 2); 44: r = mk("from", 4);
            45: r = mk("as", 2); 46: r = mk("is", 2); 47: r = mk("was", 3);
            48: r = mk("are", 3); 49: r = mk("were", 4); 50: r = mk("been", 4);
            51: r = mk("be", 2); 52: r = mk("have", 4); 53: r = mk("has", 3);
            54: r = mk("had", 3); 55: r = mk("do", 2); 56: r = mk("does", 4);
            57: r = mk("did", 3); 58: r = mk("will", 4); 59: r = mk("would", 5);
            60: r = mk("could", 5); 61: r = mk("should", 6); 62: r = mk("may", 3);
            63: r = mk("might", 5); 64: r = mk("must", 4); 65: r = mk("shall", 5);
            66: r = mk("can", 3); 67: r = mk("need", 4); 68: r = mk("it", 2);
            69: r = mk("its", 3); 70: r = mk("this", 4); 71: r = mk("that", 4);
            72: r = mk("these", 5); 73: r = mk("those", 5); 74: r = mk("i", 1);
            75: r = mk("you", 3); 76: r = mk("he", 2); 77: r = mk("she", 3);
            78: r = mk("we", 2); 79: r = mk("they", 4); 80: r = mk("what", 4);
            81: r = mk("which", 5); 82: r = mk("who", 3); 83: r = mk("whom", 4);
            84: r = mk("whose", 5); 85: r = mk("if", 2); 86: r = mk("then", 4);
            87: r = mk("else", 4); 88: r = mk("when", 4); 89: r = mk("where", 5);
            90: r = mk("why", 3); 91: r = mk("how", 3); 92: r = mk("all", 3);
            93: r = mk("each", 4); 94: r = mk("every", 5); 95: r = mk("both", 4);
            96: r = mk("few", 3); 97: r = mk("more", 4); 98: r = mk("most", 4);
            99: r = mk("other", 5); 100: r = mk("some", 4); 101: r = mk("such", 4);
            102: r = mk("no", 2); 103: r = mk("nor", 3); 104: r = mk("not", 3);
            105: r = mk("only", 4); 106: r = mk("own", 3); 107: r = mk("same", 4);
            108: r = mk("so", 2); 109: r = mk("than", 4); 110: r = mk("too", 3);
            111: r = mk("very", 4); 112: r = mk("just", 4); 113: r = mk("also", 4);
            114: r = mk("now", 3); 115: r = mk("here", 4); 116: r = mk("there", 5);
            117: r = mk("about", 5); 118: r = mk("into", 4);
            119: r = mk("through", 7); 120: r = mk("during", 6);
            121: r = mk("before", 6); 122: r = mk("after", 5);
            123: r = mk("above", 5); 124: r = mk("below", 5);
            125: r = mk("between", 7);
            default: r = '0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic start;
        logic [4:0] len;
    } t_scan_req;
endpackage

>>> src/tsf_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/tsf_rom_scan.sv
// Stop-word lookup: walks the ROM one row a cycle against a packed token.
// Depends on tsf_pkg.
module tsf_rom_scan #(
    parameter int ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsf_pkg::t_scan_req i_req,
    input  tsf_pkg::t_row i_token,
    output logic          o_done,
    output logic          o_hit
);
    import tsf_pkg::*;
    localparam int AW = $clog2(ENTRIES);
    logic [AW-1:0] r_addr;
    logic          r_busy, r_hit, r_done;
    t_row          r_row, r_tok;
    logic          r_rv;
    logic [4:0]    r_len;
    logic [4:0]    w_rlen;
    t_row          w_mask;

    always_comb begin
        w_rlen = 5'd16;
        for (int i = RowBytes - 1; i >= 0; i--)
            if (r_row[i*8 +: 8] == 8'h00) w_rlen = 5'(i);
    end

    // drop stale bytes beyond the token length
    always_comb begin
        for (int i = 0; i < RowBytes; i++)
            w_mask[i*8 +: 8] = (i < int'(i_req.len)) ? 8'hFF : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        r_row <= rom_row(int'(r_addr));
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_rv <= 1'b0; r_hit <= 1'b0;
            r_addr <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1; r_addr <= '0; r_rv <= 1'b0; r_hit <= 1'b0;
                r_tok <= i_token & w_mask; r_len <= i_req.len;
            end else if (r_busy) begin
                r_rv <= 1'b1;
                if (r_addr != AW'(ENTRIES - 1)) r_addr <= r_addr + 1'b1;
                if (r_rv && w_rlen == r_len && w_rlen != 5'd0 && r_row == r_tok)
                    r_hit <= 1'b1;
                if (r_addr == AW'(ENTRIES - 1) && r_rv) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
    end

    // last row is checked on the done edge
    assign o_done = r_done;
    assign o_hit  = r_hit || (w_rlen == r_len && w_rlen != 5'd0 && r_row == r_tok);
endmodule

>>> src/text_tokenizer_stopword_filter_core.sv
// Stop-word filtering tokenizer. Input items take one cycle each inside a token while the output slot is free;
// a token end starts the ROM walk and, for a kept token, the emission of its bytes,
// with no input taken meanwhile. A buffer overflow flushes TOKEN_BUFFER_BYTES bytes.
// Reset (synchronous, active low) clears fill, passthrough, held byte and sets
// the minimum length to 2; the token buffer RAM is not cleared.
module text_tokenizer_stopword_filter_core #(
    parameter int TOKEN_BUFFER_BYTES = 16,
    parameter int STOP_WORD_ENTRIES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_token_byte,
    output logic       o_token_last,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data
);
    import tsf_pkg::*;
    localparam int AW = $clog2(TOKEN_BUFFER_BYTES);
    localparam int FW = $clog2(TOKEN_BUFFER_BYTES + 1);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_EMIT = 3'd2,
                           S_FLUSH = 3'd3, S_TAIL = 3'd4;

    logic [2:0]    r_state;
    logic [FW-1:0] r_fill, r_idx;
    logic          r_pass, r_eot, r_rd_v, r_kill;
    logic [7:0]    r_held, r_newc;
    logic [4:0]    r_min;
    t_row          r_tok;
    logic          r_ov, r_ol;
    logic [7:0]    r_ob;
    logic [7:0]    w_c, w_rd;
    logic          w_sep, w_acc, w_ofree, w_done, w_hit;
    logic [FW-1:0] w_len;
    logic          w_kill, w_load;
    t_scan_req     w_req;

    assign w_sep   = is_sep(i_text_byte);
    assign w_c     = (i_text_byte >= "A" && i_text_byte <= "Z") ? i_text_byte + 8'd32
                                                                  : i_text_byte;
    assign w_ofree = !r_ov || i_ready;
    // passthrough emits a byte, so it needs the output slot free
    assign o_ready = (r_state == S_IDLE) && w_ofree;
    assign w_acc   = i_valid && o_ready;

    // length of the token closed by this item
    assign w_len  = w_sep ? r_fill : r_fill + 1'b1;
    assign w_kill = int'(w_len) < int'(r_min);

    tsf_ram #(.WIDTH(8), .DEPTH(TOKEN_BUFFER_BYTES)) u_buf (
        .i_clk(i_clk), .i_we(w_acc && !w_sep && !r_pass &&
                              r_fill < FW'(TOKEN_BUFFER_BYTES)),
        .i_waddr(r_fill[AW-1:0]), .i_wdata(w_c),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(w_rd)
    );

    always_comb begin
        w_req.start = w_acc && !r_pass &&
                      ((w_sep && r_fill != '0) ||
                       (!w_sep && i_end_of_text && r_fill < FW'(TOKEN_BUFFER_BYTES)));
        w_req.len   = (int'(w_len) > RowBytes) ? 5'd0 : 5'(w_len);
    end

    // token bytes collected for the lookup
    t_row w_tok_n;
    always_comb begin
        w_tok_n = r_tok;
        if (w_acc && !w_sep && !r_pass && int'(r_fill) < RowBytes &&
            r_fill < FW'(TOKEN_BUFFER_BYTES))
            w_tok_n[r_fill[3:0]*8 +: 8] = w_c;
    end

    tsf_rom_scan #(.ENTRIES(STOP_WORD_ENTRIES)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .i_token(w_tok_n), .o_done(w_done), .o_hit(w_hit)
    );

    // an output item is loaded this cycle
    always_comb begin
        case (r_state)
            S_IDLE:          w_load = w_acc && r_pass;
            S_EMIT, S_FLUSH: w_load = r_rd_v && w_ofree;
            S_TAIL:          w_load = w_ofree;
            default:         w_load = 1'b0;
        endcase
    end

    assign o_valid      = r_ov;
    assign o_token_byte = r_ob;
    assign o_token_last = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_fill <= '0; r_pass <= 1'b0; r_held <= '0;
            r_min <= 5'd2; r_ov <= 1'b0; r_idx <= '0; r_rd_v <= 1'b0;
            r_eot <= 1'b0; r_kill <= 1'b0;
        end else begin
            if (i_cfg_we) r_min <= i_cfg_data;
            if (w_load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            r_tok <= w_tok_n;
            case (r_state)
                S_IDLE: if (w_acc) begin
                    if (!w_sep && r_pass) begin
                        r_ob <= r_held; r_ol <= 1'b0; r_held <= w_c;
                        if (i_end_of_text) r_state <= S_TAIL;
                    end else if (!w_sep && r_fill < FW'(TOKEN_BUFFER_BYTES)) begin
                        r_fill <= r_fill + 1'b1;
                        if (i_end_of_text) begin
                            r_state <= S_SCAN;
                            r_kill <= w_kill;
                        end
                    end else if (!w_sep) begin
                        r_newc <= w_c; r_eot <= i_end_of_text;
                        r_idx <= '0; r_rd_v <= 1'b0; r_state <= S_FLUSH;
                    end else if (r_pass) begin
                        r_ob <= r_held; r_ol <= 1'b1; r_pass <= 1'b0;
                    end else if (r_fill != '0) begin
                        r_state <= S_SCAN; r_kill <= w_kill;
                    end
                end
                S_SCAN: if (w_done) begin
                    if (w_hit || r_kill) begin
                        r_fill <= '0; r_state <= S_IDLE;
                    end else begin
                        r_idx <= '0; r_rd_v <= 1'b0; r_state <= S_EMIT;
                    end
                end
                S_EMIT, S_FLUSH: begin
                    // read one ahead; the RAM output is valid in the next cycle
                    if (!r_rd_v) begin
                        r_rd_v <= 1'b1;
                    end else if (w_ofree) begin
                        r_ob <= w_rd;
                        r_ol <= (r_state == S_EMIT) && (r_idx + 1'b1 == r_fill);
                        r_rd_v <= 1'b0;
                        if (r_idx + 1'b1 == r_fill) begin
                            r_fill <= '0;
                            if (r_state == S_FLUSH) begin
                                r_pass <= 1'b1; r_held <= r_newc;
                                r_state <= r_eot ? S_TAIL : S_IDLE;
                            end else r_state <= S_IDLE;
                        end else r_idx <= r_idx + 1'b1;
                    end
                end
                S_TAIL: if (w_ofree) begin
                    r_ob <= r_held; r_ol <= 1'b1;
                    r_pass <= 1'b0; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/tsf_checker.sv
// Port-level checker for the stop-word filter, bound to the top level.
// Depends on text_tokenizer_stopword_filter_core_defines.svh.
`include "text_tokenizer_stopword_filter_core_defines.svh"
module tsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_token_byte,
    input logic       o_token_last
);
    `TSF_ASSERT_NEXT(a_hold, o_valid && !i_ready, o_valid && $stable(o_token_byte), "item dropped")
    `TSF_ASSERT_IMPL(a_rdy, o_ready && o_valid, i_ready, "input taken while output stalled")
    `TSF_ASSERT_NEXT(a_last, o_valid && !i_ready, $stable(o_token_last), "last flag changed")
endmodule

bind text_tokenizer_stopword_filter_core tsf_checker u_chk (.*);
